// ----- rtl/core/atcc_pkg.sv -----
// shared types, opcode masks and the popcount helper for the cycle cost estimator
// no dependencies
`default_nettype none

package atcc_pkg;

    typedef logic [5:0] t_cost;

    localparam logic [15:0] THUMB_HIREG_MASK = 16'h0FC0;
    localparam logic [15:0] THUMB_HIREG_BX   = 16'h0340;

    localparam logic [31:0] ARM_BX_MASK   = 32'h0FFFFFD0;
    localparam logic [31:0] ARM_BX_MATCH  = 32'h012FFF10;
    localparam logic [31:0] ARM_SWP_MASK  = 32'h0FB00FF0;
    localparam logic [31:0] ARM_SWP_MATCH = 32'h01000090;
    localparam logic [31:0] ARM_MUL_MASK  = 32'h0FC000F0;
    localparam logic [31:0] ARM_MUL_MATCH = 32'h00000090;
    localparam logic [31:0] ARM_MULL_MASK = 32'h0F8000F0;
    localparam logic [31:0] ARM_MULL_MATCH = 32'h00800090;
    localparam logic [31:0] ARM_RSH_MASK  = 32'h02000090;
    localparam logic [31:0] ARM_RSH_MATCH = 32'h00000010;
    localparam logic [31:0] ARM_CLASS_MASK = 32'h0E000000;

    localparam t_cost COST_ONE = 6'd1;

    function automatic logic [4:0] popcount16(input logic [15:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 16; i++) begin
            n = n + {4'd0, v[i]};
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/arm_thumb_cycle_cost_estimator_core.sv -----
// top level of the static cycle cost estimator: input register, decoders, result register
// depends on atcc_pkg, atcc_thumb_dec and atcc_arm_dec
// a taken item passes through the input register and then the result register before the result strobe
// throughput: one item per cycle, busy is never raised
// reset: synchronous active low, clears the valid flags only
// the receiver cannot stall: each result is shown for exactly one cycle
`default_nettype none

module arm_thumb_cycle_cost_estimator_core
    import atcc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_req_type,
    input  wire logic [31:0] i_opcode,
    output logic             o_valid,
    output t_cost            o_cycle_cost
);

    logic        r_in_vld;
    logic        r_req_type;
    logic [31:0] r_opcode;
    logic        r_out_vld;
    t_cost       r_cycle_cost;
    t_cost       n_cycle_cost;
    t_cost       w_thumb_cost;
    t_cost       w_arm_cost;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= start && !busy;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req_type <= i_req_type;
            r_opcode   <= i_opcode;
        end
        if (r_in_vld) begin
            r_cycle_cost <= n_cycle_cost;
        end
    end

    atcc_thumb_dec u_thumb_dec (
        .i_opcode (r_opcode[15:0]),
        .o_cost   (w_thumb_cost)
    );

    atcc_arm_dec u_arm_dec (
        .i_opcode (r_opcode),
        .o_cost   (w_arm_cost)
    );

    assign n_cycle_cost = r_req_type ? w_thumb_cost : w_arm_cost;

    assign o_valid      = r_out_vld;
    assign o_cycle_cost = r_cycle_cost;

    // every taken item gives a result
    a_item_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##2 o_valid)
        else $error("item taken without a result");

    // costs stay within 1 to 36
    a_cost_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cycle_cost != 6'd0 && o_cycle_cost <= 6'd36))
        else $error("cycle cost out of range");

    // thumb long branch pair always costs four
    a_thumb_bl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_req_type && r_opcode[15:12] == 4'hF) |=> o_cycle_cost == 6'd4)
        else $error("thumb branch cost mismatch");

    // arm nv space always costs one
    a_arm_nv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !r_req_type && r_opcode[31:28] == 4'hF) |=> o_cycle_cost == COST_ONE)
        else $error("nv cost mismatch");

endmodule

`default_nettype wire

// ----- rtl/core/atcc_thumb_dec.sv -----
// cycle cost decode for a 16-bit thumb opcode
// depends on atcc_pkg
`default_nettype none

module atcc_thumb_dec
    import atcc_pkg::*;
(
    input  wire logic [15:0] i_opcode,
    output t_cost            o_cost
);

    logic [4:0] w_pop;
    logic [3:0] w_push_n;
    logic [3:0] w_ldm_n;
    logic [3:0] w_alu_op;

    assign w_pop    = popcount16({8'd0, i_opcode[7:0]});
    assign w_push_n = w_pop[3:0] + {3'd0, i_opcode[8]};
    assign w_ldm_n  = (w_pop == 5'd0) ? 4'd1 : w_pop[3:0];
    assign w_alu_op = i_opcode[9:6];

    always_comb begin
        o_cost = COST_ONE;
        case (i_opcode[15:12])
            4'h4: begin
                if ((i_opcode & THUMB_HIREG_MASK) == THUMB_HIREG_BX) begin
                    o_cost = 6'd4;
                end else if (!i_opcode[10] && (w_alu_op == 4'd2 || w_alu_op == 4'd3 ||
                                               w_alu_op == 4'd4 || w_alu_op == 4'd7)) begin
                    o_cost = 6'd2;
                end
            end
            4'h5: begin
                o_cost = (i_opcode[11:9] >= 3'd3) ? 6'd5 : 6'd3;
            end
            4'h6, 4'h9: begin
                o_cost = i_opcode[11] ? 6'd5 : 6'd3;
            end
            4'h7, 4'h8: begin
                o_cost = i_opcode[11] ? 6'd4 : 6'd3;
            end
            4'hB: begin
                if (i_opcode[11:8] != 4'd0 && i_opcode[10:9] == 2'b10) begin
                    o_cost = (i_opcode[11] ? 6'd2 : 6'd3) + {1'b0, w_push_n, 1'b0};
                end
            end
            4'hC: begin
                o_cost = 6'd2 + {1'b0, w_ldm_n, 1'b0};
            end
            4'hF: begin
                o_cost = 6'd4;
            end
            default: begin
                o_cost = COST_ONE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/atcc_arm_dec.sv -----
// cycle cost decode for a 32-bit arm opcode
// depends on atcc_pkg
`default_nettype none

module atcc_arm_dec
    import atcc_pkg::*;
(
    input  wire logic [31:0] i_opcode,
    output t_cost            o_cost
);

    logic [4:0] w_pop;
    logic [4:0] w_n;
    logic       w_ls_single;
    logic       w_halfword;
    logic       w_block;
    logic       w_bx;
    logic       w_swp;
    logic       w_mul;
    logic       w_reg_shift;
    logic       w_pc_write;

    assign w_pop = popcount16(i_opcode[15:0]);
    assign w_n   = (w_pop == 5'd0) ? 5'd1 : w_pop;

    assign w_ls_single = i_opcode[27:26] == 2'b01;
    assign w_halfword  = (i_opcode & ARM_CLASS_MASK) == 32'd0 && i_opcode[7] && i_opcode[4] &&
                         i_opcode[6:5] != 2'b00;
    assign w_block     = i_opcode[27:25] == 3'b100;
    assign w_bx        = (i_opcode & ARM_BX_MASK) == ARM_BX_MATCH;
    assign w_swp       = (i_opcode & ARM_SWP_MASK) == ARM_SWP_MATCH;
    assign w_mul       = (i_opcode & ARM_MUL_MASK) == ARM_MUL_MATCH ||
                         (i_opcode & ARM_MULL_MASK) == ARM_MULL_MATCH;
    assign w_reg_shift = i_opcode[27:26] == 2'b00 &&
                         (i_opcode & ARM_RSH_MASK) == ARM_RSH_MATCH;
    assign w_pc_write  = i_opcode[27:26] == 2'b00 && i_opcode[15:12] == 4'hF &&
                         !(i_opcode[24:23] == 2'b10 && !i_opcode[20]);

    always_comb begin
        o_cost = COST_ONE;
        if (i_opcode[31:28] == 4'hF) begin
            o_cost = COST_ONE;
        end else if (w_ls_single) begin
            if (i_opcode[20] && !i_opcode[22] && i_opcode[15:12] == 4'hF) begin
                o_cost = 6'd7;
            end else if (i_opcode[20]) begin
                o_cost = i_opcode[22] ? 6'd4 : 6'd5;
            end else begin
                o_cost = 6'd3;
            end
        end else if (w_halfword) begin
            o_cost = i_opcode[20] ? 6'd4 : 6'd3;
        end else if (w_block) begin
            if (i_opcode[20]) begin
                o_cost = (i_opcode[15] ? 6'd4 : 6'd2) + {w_n, 1'b0};
            end else begin
                o_cost = 6'd2 + {1'b0, w_n};
            end
        end else if (w_bx) begin
            o_cost = 6'd3;
        end else if (w_swp) begin
            o_cost = i_opcode[22] ? 6'd6 : 6'd7;
        end else if (w_mul) begin
            case ({i_opcode[23], i_opcode[21]})
                2'b11:   o_cost = 6'd5;
                2'b10:   o_cost = 6'd4;
                2'b01:   o_cost = 6'd4;
                default: o_cost = 6'd3;
            endcase
        end else if (w_reg_shift) begin
            o_cost = 6'd2;
        end else if (w_pc_write) begin
            o_cost = ((i_opcode & 32'h02000010) == 32'h00000010 && !i_opcode[7]) ? 6'd4 : 6'd3;
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb_arm_thumb_cycle_cost_estimator_core.sv -----
// self-checking testbench for arm_thumb_cycle_cost_estimator_core: directed and random
// instruction words, each result checked against an in-bench cycle cost predictor
// depends on atcc_pkg and arm_thumb_cycle_cost_estimator_core
`timescale 1ns / 100ps

module tb_arm_thumb_cycle_cost_estimator_core;

    import atcc_pkg::t_cost;

    localparam int WATCHDOG_LIMIT = 1000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_req_type = 1'b0;
    logic [31:0] i_opcode = 32'h0;
    logic        o_valid;
    t_cost       o_cycle_cost;

    t_cost expected_costs[$];
    int    error_count = 0;
    int    idle_pct = 0;
    int    stall_cycles = 0;

    arm_thumb_cycle_cost_estimator_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_opcode     (i_opcode),
        .o_valid      (o_valid),
        .o_cycle_cost (o_cycle_cost)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_cost predict_cycle_cost(input logic thumb, input logic [31:0] op);
        logic [15:0] t;
        int n;
        int cost;
        t = op[15:0];
        cost = 1;
        if (thumb) begin
            case (t[15:12])
                4'h4: begin
                    if (t[11:6] == 6'b001101) begin
                        cost = 4;
                    end else if (!t[10] && (t[9:6] == 4'd2 || t[9:6] == 4'd3 ||
                                            t[9:6] == 4'd4 || t[9:6] == 4'd7)) begin
                        cost = 2;
                    end
                end
                4'h5: cost = (t[11:9] >= 3'd3) ? 5 : 3;
                4'h6, 4'h9: cost = t[11] ? 5 : 3;
                4'h7, 4'h8: cost = t[11] ? 4 : 3;
                4'hB: begin
                    if (t[11:8] != 4'h0 && t[10:9] == 2'b10) begin
                        n = $countones(t[7:0]) + int'(t[8]);
                        cost = (t[11] ? 2 : 3) + 2 * n;
                    end
                end
                4'hC: begin
                    n = $countones(t[7:0]);
                    if (n == 0) n = 1;
                    cost = 2 + 2 * n;
                end
                4'hF: cost = 4;
                default: cost = 1;
            endcase
        end else if (op[31:28] == 4'hF) begin
            cost = 1;
        end else if (op[27:26] == 2'b01) begin
            if (op[20] && !op[22] && op[15:12] == 4'hF) cost = 7;
            else if (op[20]) cost = op[22] ? 4 : 5;
            else cost = 3;
        end else if (op[27:25] == 3'b000 && op[7] && op[4] && op[6:5] != 2'b00) begin
            cost = op[20] ? 4 : 3;
        end else if (op[27:25] == 3'b100) begin
            n = $countones(op[15:0]);
            if (n == 0) n = 1;
            if (op[20]) cost = (op[15] ? 4 : 2) + 2 * n;
            else cost = 2 + n;
        end else if ((op & 32'h0FFFFFD0) == 32'h012FFF10) begin
            cost = 3;
        end else if ((op & 32'h0FB00FF0) == 32'h01000090) begin
            cost = op[22] ? 6 : 7;
        end else if ((op & 32'h0FC000F0) == 32'h00000090 ||
                     (op & 32'h0F8000F0) == 32'h00800090) begin
            cost = op[23] ? (op[21] ? 5 : 4) : (op[21] ? 4 : 3);
        end else if (op[27:26] == 2'b00 && !op[25] && !op[7] && op[4]) begin
            cost = 2;
        end else if (op[27:26] == 2'b00 && op[15:12] == 4'hF &&
                     !(op[24:23] == 2'b10 && !op[20])) begin
            cost = (!op[25] && op[4] && !op[7]) ? 4 : 3;
        end
        return t_cost'(cost);
    endfunction

    task automatic issue_instruction(input logic thumb, input logic [31:0] op);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_req_type <= thumb;
        i_opcode   <= op;
        do @(posedge i_clk); while (busy !== 1'b0);
        expected_costs.push_back(predict_cycle_cost(thumb, op));
    endtask

    task automatic make_random_item(output logic thumb, output logic [31:0] op);
        logic [31:0] r;
        logic [15:0] reg_list;
        logic [3:0]  thumb_classes [9];
        thumb_classes = '{4'h4, 4'h5, 4'h6, 4'h7, 4'h8, 4'h9, 4'hB, 4'hC, 4'hF};
        r = $urandom;
        thumb = 1'b0;
        case ($urandom_range(3))
            0: reg_list = 16'h0;
            1: reg_list = 16'h1 << $urandom_range(15);
            default: reg_list = r[15:0];
        endcase
        case ($urandom_range(11))
            0: begin
                op = r;
                thumb = 1'($urandom_range(1));
            end
            1: begin
                op = {r[31:28], 2'b01, r[25:0]};
                if ($urandom_range(2) == 0) op[15:12] = 4'hF;
            end
            2: op = {r[31:28], 3'b000, r[24:8], 1'b1, r[6:5], 1'b1, r[3:0]};
            3: op = {r[31:28], 3'b100, r[24:16], reg_list};
            4: op = (r & ~32'h0FFFFFD0) | 32'h012FFF10;
            5: op = (r & ~32'h0FB00FF0) | 32'h01000090;
            6: op = (r & ~32'h0FC000F0) | 32'h00000090;
            7: op = (r & ~32'h0F8000F0) | 32'h00800090;
            8: op = {r[31:28], 2'b00, r[25:16], 4'hF, r[11:0]};
            default: begin
                thumb = 1'b1;
                op = r;
                op[15:12] = thumb_classes[$urandom_range(8)];
                if (op[15:12] == 4'h4 && $urandom_range(2) == 0) op[11:6] = 6'b001101;
                if (op[15:12] == 4'hB && $urandom_range(3) != 0) op[10:9] = 2'b10;
                if (op[15:12] == 4'hB || op[15:12] == 4'hC) op[7:0] = reg_list[7:0];
            end
        endcase
    endtask

    task automatic test_thumb_classes();
        issue_instruction(1'b1, 32'h0000_4340);
        issue_instruction(1'b1, 32'h0000_4080);
        issue_instruction(1'b1, 32'h0000_5800);
        issue_instruction(1'b1, 32'h0000_5000);
        issue_instruction(1'b1, 32'h0000_6800);
        issue_instruction(1'b1, 32'h0000_8000);
        issue_instruction(1'b1, 32'h0000_B5FF);
        issue_instruction(1'b1, 32'h0000_BDFF);
        issue_instruction(1'b1, 32'h0000_CFFF);
        issue_instruction(1'b1, 32'h0000_F000);
    endtask

    task automatic test_arm_classes();
        issue_instruction(1'b0, 32'hE59F_F000);
        issue_instruction(1'b0, 32'hE5D0_0000);
        issue_instruction(1'b0, 32'hE1D0_00B0);
        issue_instruction(1'b0, 32'hE8BD_FFFF);
        issue_instruction(1'b0, 32'hE12F_FF1E);
        issue_instruction(1'b0, 32'hE100_0091);
        issue_instruction(1'b0, 32'hE0A0_0291);
        issue_instruction(1'b0, 32'hE1A0_0110);
        issue_instruction(1'b0, 32'hE1A0_F000);
    endtask

    // nv condition, empty lists, ignored thumb upper half, unclassified encodings
    task automatic test_special_cases();
        issue_instruction(1'b0, 32'hFFFF_FFFF);
        issue_instruction(1'b1, 32'h0000_B400);
        issue_instruction(1'b1, 32'h0000_C000);
        issue_instruction(1'b0, 32'hE880_0000);
        issue_instruction(1'b1, 32'hFFFF_4340);
        issue_instruction(1'b0, 32'h0000_0000);
        issue_instruction(1'b0, 32'hEE00_0000);
    endtask

    task automatic test_random(input int count, input int pct);
        logic        thumb;
        logic [31:0] op;
        idle_pct = pct;
        repeat (count) begin
            make_random_item(thumb, op);
            issue_instruction(thumb, op);
        end
    endtask

    always @(posedge i_clk) begin
        t_cost want;
        if (o_valid === 1'b1) begin
            if (expected_costs.size() == 0) begin
                $error("unexpected result: cycle_cost %0d", o_cycle_cost);
                error_count++;
            end else begin
                want = expected_costs.pop_front();
                if (o_cycle_cost !== want) begin
                    $error("cycle_cost mismatch: expected %0d, actual %0d", want, o_cycle_cost);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_valid === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("arm_thumb_cycle_cost_estimator_core regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_thumb_classes();
        test_arm_classes();
        test_special_cases();
        test_random(520, 0);
        test_random(520, 77);
        test_random(520, 28);
        start <= 1'b0;
        while (expected_costs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("arm_thumb_cycle_cost_estimator_core regression: pass");
        end else begin
            $display("arm_thumb_cycle_cost_estimator_core regression: fail");
        end
        $finish;
    end

endmodule
